[rtl/msfb_pkg.sv]
// ----------------------------------------------------------------------------
// msfb_pkg
// shared types, codes and frame constants for the meter spi frame builder
// ----------------------------------------------------------------------------
package msfb_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;
    localparam logic [1:0] CMD_RESP  = 2'd3;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [7:0]  CHK_BASE      = 8'h33;
    localparam logic [7:0]  OFS_CMD       = 8'hFE;
    localparam logic [31:0] MAGIC_ENABLE  = 32'h4A985B67;
    localparam logic [31:0] MAGIC_DISABLE = 32'h76B589A4;
    localparam logic [31:0] INIT_KEY      = 32'h5A7896B4;

    localparam logic [2:0] FRAME_LAST = 3'd5;

    localparam int TDATA_IN_W  = 48;
    localparam int TDATA_OUT_W = 48;

    typedef struct packed {
        logic        resp;
        logic        has_ofs;
        logic        ofs_en;
        logic [7:0]  cmd;
        logic [31:0] data;
        logic [7:0]  chk;
        logic        ok;
    } t_job;

    function automatic logic [7:0] frame_chk(input logic [7:0] cmd, input logic [31:0] data);
        logic [7:0] s;
        s = cmd + data[7:0] + data[15:8] + data[23:16] + data[31:24];
        return CHK_BASE + ~s;
    endfunction

    localparam logic [7:0] CHK_OFS_ON  = frame_chk(OFS_CMD, MAGIC_ENABLE);
    localparam logic [7:0] CHK_OFS_OFF = frame_chk(OFS_CMD, MAGIC_DISABLE);

endpackage

[rtl/meter_spi_frame_builder.sv]
// ----------------------------------------------------------------------------
// meter_spi_frame_builder
// turns register requests into six-byte spi frames and checks read responses
// ----------------------------------------------------------------------------
// input stream: tuser carries the command (write, read, init, read response),
// tdata carries address, write data and received checksum. output stream:
// one word per frame byte (tuser = 0) or one checked read result (tuser = 1),
// tlast on the final word of each request.
// a write or read gives 6 words, or 12 when the high page offset has to be
// switched first; init gives 6 words; a read response gives 1 word.
// the first word of a request is registered in the job queue and then in
// the output register; words then follow one per cycle while the output
// is not stalled.
// a two-entry job queue sits between the request front and the sequencer;
// input is taken while the queue has room, even when the output is stalled.
// a stalled output word holds until taken; the sequencer waits with it.
// reset clears offset mode, pending read command, queue and output valid.
// ----------------------------------------------------------------------------
module meter_spi_frame_builder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [msfb_pkg::TDATA_IN_W-1:0]  i_s_tdata,   // address, write_data, rx_checksum
    input  logic [1:0]                       i_s_tuser,   // command
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [msfb_pkg::TDATA_OUT_W-1:0] o_m_tdata,   // tx_byte, read_value, checksum_ok
    output logic                             o_m_tuser,   // kind
    output logic                             o_m_tlast
);

    logic           accept;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    msfb_pkg::t_job new_job;
    msfb_pkg::t_job head_job;
    logic [7:0]     tx_byte;
    logic [31:0]    read_value;
    logic           checksum_ok;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    msfb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_command     (i_s_tuser),
        .i_address     (i_s_tdata[7:0]),
        .i_write_data  (i_s_tdata[39:8]),
        .i_rx_checksum (i_s_tdata[47:40]),
        .o_job         (new_job)
    );

    msfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_job   (new_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    msfb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (q_valid),
        .i_head        (head_job),
        .o_pop         (q_pop),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_kind        (o_m_tuser),
        .o_tx_byte     (tx_byte),
        .o_read_value  (read_value),
        .o_checksum_ok (checksum_ok),
        .o_last        (o_m_tlast)
    );

    assign o_m_tdata = {7'd0, checksum_ok, read_value, tx_byte};

endmodule

[rtl/msfb_front.sv]
// ----------------------------------------------------------------------------
// msfb_front
// classifies requests, keeps page and pending read state, builds frame jobs
// ----------------------------------------------------------------------------
module msfb_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_address,
    input  logic [31:0]        i_write_data,
    input  logic [7:0]         i_rx_checksum,
    output msfb_pkg::t_job     o_job
);

    logic       r_ofs_en;
    logic [7:0] r_pend_cmd;
    logic       n_ofs_en;
    logic [7:0] n_pend_cmd;
    logic [7:0] req_cmd;
    logic [7:0] resp_sum;
    logic [7:0] resp_exp;

    assign req_cmd  = {i_address[6:0], (i_command == msfb_pkg::CMD_READ)};
    assign resp_sum = r_pend_cmd + i_write_data[7:0] + i_write_data[15:8]
                    + i_write_data[23:16] + i_write_data[31:24];
    assign resp_exp = msfb_pkg::CHK_BASE + ~resp_sum;

    always_comb begin
        n_ofs_en   = r_ofs_en;
        n_pend_cmd = r_pend_cmd;
        o_job      = '0;
        unique case (i_command) inside
            msfb_pkg::CMD_WRITE, msfb_pkg::CMD_READ: begin
                o_job.has_ofs = (i_address[7] != r_ofs_en);
                o_job.ofs_en  = i_address[7];
                o_job.cmd     = req_cmd;
                n_ofs_en      = i_address[7];
                if (i_command == msfb_pkg::CMD_READ) begin
                    n_pend_cmd = req_cmd;
                end else begin
                    o_job.data = i_write_data;
                    o_job.chk  = msfb_pkg::frame_chk(req_cmd, i_write_data);
                end
            end
            msfb_pkg::CMD_INIT: begin
                o_job.cmd  = msfb_pkg::OFS_CMD;
                o_job.data = msfb_pkg::INIT_KEY;
                o_job.chk  = msfb_pkg::frame_chk(msfb_pkg::OFS_CMD, msfb_pkg::INIT_KEY);
            end
            default: begin
                o_job.resp = 1'b1;
                o_job.data = i_write_data;
                o_job.ok   = (resp_exp == i_rx_checksum);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ofs_en   <= 1'b0;
            r_pend_cmd <= '0;
        end else if (i_accept) begin
            r_ofs_en   <= n_ofs_en;
            r_pend_cmd <= n_pend_cmd;
        end
    end

endmodule

[rtl/msfb_queue.sv]
// ----------------------------------------------------------------------------
// msfb_queue
// two-entry job queue between the request front and the byte sequencer
// ----------------------------------------------------------------------------
module msfb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  msfb_pkg::t_job     i_job,
    output logic               o_full,
    output logic               o_valid,
    output msfb_pkg::t_job     o_job,
    input  logic               i_pop
);

    msfb_pkg::t_job r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");

endmodule

[rtl/msfb_back.sv]
// ----------------------------------------------------------------------------
// msfb_back
// walks the head job byte by byte into a registered output word
// ----------------------------------------------------------------------------
module msfb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  msfb_pkg::t_job     i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_kind,
    output logic [7:0]         o_tx_byte,
    output logic [31:0]        o_read_value,
    output logic               o_checksum_ok,
    output logic               o_last
);

    logic [2:0]  r_seq;
    logic        r_ofs_done;
    logic        r_valid;
    logic        r_kind;
    logic [7:0]  r_tx_byte;
    logic [31:0] r_read_value;
    logic        r_ok;
    logic        r_last;

    logic        in_ofs;
    logic [7:0]  f_cmd;
    logic [31:0] f_data;
    logic [7:0]  f_chk;
    logic [7:0]  cur_byte;
    logic        end_frame;
    logic        job_done;
    logic        fire;

    assign in_ofs    = i_head.has_ofs && !r_ofs_done;
    assign end_frame = (r_seq == msfb_pkg::FRAME_LAST);
    assign job_done  = i_head.resp || (end_frame && !in_ofs);
    assign fire      = i_head_valid && (!r_valid || i_ready);
    assign o_pop     = fire && job_done;

    always_comb begin
        if (in_ofs) begin
            f_cmd  = msfb_pkg::OFS_CMD;
            f_data = i_head.ofs_en ? msfb_pkg::MAGIC_ENABLE : msfb_pkg::MAGIC_DISABLE;
            f_chk  = i_head.ofs_en ? msfb_pkg::CHK_OFS_ON : msfb_pkg::CHK_OFS_OFF;
        end else begin
            f_cmd  = i_head.cmd;
            f_data = i_head.data;
            f_chk  = i_head.chk;
        end
    end

    always_comb begin
        case (r_seq)
            3'd0:    cur_byte = f_cmd;
            3'd1:    cur_byte = f_data[7:0];
            3'd2:    cur_byte = f_data[15:8];
            3'd3:    cur_byte = f_data[23:16];
            3'd4:    cur_byte = f_data[31:24];
            default: cur_byte = f_chk;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq      <= '0;
            r_ofs_done <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                if (job_done) begin
                    r_seq      <= '0;
                    r_ofs_done <= 1'b0;
                end else if (end_frame) begin
                    r_seq      <= '0;
                    r_ofs_done <= 1'b1;
                end else begin
                    r_seq <= r_seq + 3'd1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_last <= job_done;
            if (i_head.resp) begin
                r_kind       <= msfb_pkg::KIND_READ;
                r_tx_byte    <= '0;
                r_read_value <= i_head.data;
                r_ok         <= i_head.ok;
            end else begin
                r_kind       <= msfb_pkg::KIND_TX;
                r_tx_byte    <= cur_byte;
                r_read_value <= '0;
                r_ok         <= 1'b0;
            end
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_read_value  = r_read_value;
    assign o_checksum_ok = r_ok;
    assign o_last        = r_last;

    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq <= msfb_pkg::FRAME_LAST)
        else $error("byte index past end of frame");
    a_ofs_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ofs_done |-> (i_head_valid && i_head.has_ofs))
        else $error("main frame phase without offset job at head");
    a_resp_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_head.resp) |-> (o_pop && r_seq == 3'd0 && !r_ofs_done))
        else $error("read result not taken as a single word");

endmodule
